FILE: design/wnrd_pkg.sv
// Shared types and constants for the windowed nearest residue distance bin block.
// No dependencies; imported by the top level, the distance pipeline and the checker.
`timescale 1ns / 1ps

package wnrd_pkg;

  // Distance cap: 999 angstrom in eighths, compared on squares
  localparam int unsigned CAP_EIGHTHS = 999 * 8;
  localparam int unsigned BEST_W      = 26;
  localparam logic [BEST_W-1:0] CAP_SQ = BEST_W'(CAP_EIGHTHS * CAP_EIGHTHS);
  localparam int unsigned DSQ_W       = 35;
  localparam logic [DSQ_W-1:0] DSQ_NONE = '1;

  localparam int unsigned HALF_W = 10;
  localparam int unsigned STEP_W = 13;

  // Register map indexes
  localparam logic [2:0] REG_WINDOW_HALF  = 3'd0;
  localparam logic [2:0] REG_EXCLUDE_HALF = 3'd1;
  localparam logic [2:0] REG_STEP_ONE     = 3'd2;
  localparam logic [2:0] REG_STEP_TWO     = 3'd3;
  localparam logic [2:0] REG_STEP_THREE   = 3'd4;

  localparam logic [HALF_W-1:0] WINDOW_HALF_RST  = HALF_W'(100);
  localparam logic [HALF_W-1:0] EXCLUDE_HALF_RST = HALF_W'(12);
  localparam logic [STEP_W-1:0] STEP_ONE_RST     = STEP_W'(32);
  localparam logic [STEP_W-1:0] STEP_TWO_RST     = STEP_W'(64);
  localparam logic [STEP_W-1:0] STEP_THREE_RST   = STEP_W'(96);

  localparam logic [1:0] BIN_NONE = 2'd3;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Control that travels with each memory read beat
  typedef struct packed {
    logic valid;
    logic keep;
  } wnrd_tap_t;

endpackage

FILE: design/wnrd_dist.sv
// Squared distance pipeline with running minimum for the nearest residue search.
// Depends on wnrd_pkg; fed by the coordinate memory read port of the top level.
`timescale 1ns / 1ps

module wnrd_dist import wnrd_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  logic [3*COORD_BITS-1:0] qcoord_i,
  input  logic [3*COORD_BITS-1:0] rd_data_i,
  input  wnrd_tap_t               tap_i,
  output logic [BEST_W-1:0]       best_o,
  output logic                    found_o,
  output logic                    active_o
);

  localparam int SQ_W  = 2 * COORD_BITS + 1;
  localparam int SUM_W = 2 * COORD_BITS + 3;
  localparam int CMP_W = (SUM_W > BEST_W) ? SUM_W : BEST_W;

  logic signed [COORD_BITS:0]     diff [3];
  logic signed [2*COORD_BITS+1:0] prod [3];
  logic [SQ_W-1:0]                sq_q [3];
  wnrd_tap_t                      s2_tap_q;
  logic [SUM_W-1:0]               sum;
  logic [BEST_W-1:0]              best_q;
  logic                           found_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({qcoord_i[k*COORD_BITS+COORD_BITS-1],
                         qcoord_i[k*COORD_BITS +: COORD_BITS]})
              - $signed({rd_data_i[k*COORD_BITS+COORD_BITS-1],
                         rd_data_i[k*COORD_BITS +: COORD_BITS]});
      prod[k] = diff[k] * diff[k];
    end
  end

  // Stage two: squares per axis
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= prod[k][SQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_tap_q <= '0;
    end else begin
      s2_tap_q <= tap_i;
    end
  end

  assign sum = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);

  // Stage three: keep the smallest qualifying distance below the cap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= CAP_SQ;
      found_q <= 1'b0;
    end else if (clear_i) begin
      best_q  <= CAP_SQ;
      found_q <= 1'b0;
    end else if (s2_tap_q.valid && s2_tap_q.keep && (CMP_W'(sum) < CMP_W'(best_q))) begin
      best_q  <= BEST_W'(sum);
      found_q <= 1'b1;
    end
  end

  assign best_o   = best_q;
  assign found_o  = found_q;
  assign active_o = tap_i.valid || s2_tap_q.valid;

endmodule

FILE: design/windowed_nearest_residue_distance_bin_top.sv
// Top level of the windowed nearest residue distance bin: coordinate memory, search
// sequencer, APB register file. Depends on wnrd_pkg and wnrd_dist.
//
// Usage:
//   Command channel: drive start with the item fields; the item is taken at a rising
//   edge where start is high and busy is low.
//   An append (operation 0) writes one residue into the coordinate memory at that edge
//   and gives no result; busy stays low, so appends may follow every cycle.
//   A query (operation 1) inside the chain reads the queried residue, then sweeps the
//   N positions of its clipped window, one memory read per cycle, through a three
//   stage distance pipeline. busy is high from the cycle after acceptance until the
//   result is registered, and done_o pulses with that result.
//   A query at or past the chain length returns status 1 on the cycle after acceptance.
//   Results: done_o is high for exactly one cycle with the result fields; the receiver
//   cannot stall, so no result is ever held back.
//   Configuration: APB, five 32-bit registers at byte offsets 0 to 16; write only
//   while no query is running.
//   Reset: clears the chain length, the registers to their defaults and the sequencer;
//   the coordinate memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module windowed_nearest_residue_distance_bin_top import wnrd_pkg::*; #(
  parameter int MAX_RESIDUES = 1024,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation_i,
  input  logic                         start_chain_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  input  logic signed [COORD_BITS-1:0] coord_z_i,
  input  logic [9:0]                   query_position_i,
  output logic                         done_o,
  output logic [1:0]                   distance_bin_o,
  output logic [DSQ_W-1:0]             min_distance_sq_o,
  output logic                         neighbor_found_o,
  output logic                         status_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int AW = $clog2(MAX_RESIDUES);
  localparam int CW = $clog2(MAX_RESIDUES + 1);
  localparam int XW = (CW > 11) ? CW : 11;
  localparam int MW = 3 * COORD_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QRD   = 3'd1;
  localparam logic [2:0] S_QLD   = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     count_q;
  logic [HALF_W-1:0] win_q, excl_q;
  logic [STEP_W-1:0] step1_q, step2_q, step3_q;
  logic [BEST_W-1:0] step_sq_q [3];

  logic [XW-1:0]     pos_q, p2_q, hi_q;
  logic [XW-1:0]     pos_in, lo_in, hi_in, hi_sum, last_idx, sep;
  logic [MW-1:0]     qcoord_q;

  logic [MW-1:0]     mem [MAX_RESIDUES];
  logic [MW-1:0]     rd_data_q;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  wnrd_tap_t         s1_tap_q;

  logic              accept, take_append, take_query, in_chain, clear_best;
  logic              finish;
  logic [BEST_W-1:0] best;
  logic              found, pipe_active;
  logic [1:0]        bin;

  logic              done_q;
  logic [1:0]        bin_q;
  logic [DSQ_W-1:0]  dsq_q;
  logic              nf_q, status_q;

  // ---------------- configuration ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= WINDOW_HALF_RST;
      excl_q  <= EXCLUDE_HALF_RST;
      step1_q <= STEP_ONE_RST;
      step2_q <= STEP_TWO_RST;
      step3_q <= STEP_THREE_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_WINDOW_HALF:  win_q   <= pwdata[HALF_W-1:0];
        REG_EXCLUDE_HALF: excl_q  <= pwdata[HALF_W-1:0];
        REG_STEP_ONE:     step1_q <= pwdata[STEP_W-1:0];
        REG_STEP_TWO:     step2_q <= pwdata[STEP_W-1:0];
        REG_STEP_THREE:   step3_q <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_WINDOW_HALF:  prdata = 32'(win_q);
      REG_EXCLUDE_HALF: prdata = 32'(excl_q);
      REG_STEP_ONE:     prdata = 32'(step1_q);
      REG_STEP_TWO:     prdata = 32'(step2_q);
      REG_STEP_THREE:   prdata = 32'(step3_q);
      default:          prdata = '0;
    endcase
  end

  // Threshold squares; users must change registers only while idle; not enforced
  always_ff @(posedge clk_i) begin
    step_sq_q[0] <= BEST_W'(step1_q) * BEST_W'(step1_q);
    step_sq_q[1] <= BEST_W'(step2_q) * BEST_W'(step2_q);
    step_sq_q[2] <= BEST_W'(step3_q) * BEST_W'(step3_q);
  end

  // ---------------- command decode ----------------
  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign take_append = accept && (operation_i == OP_APPEND);
  assign take_query  = accept && (operation_i == OP_QUERY);

  assign pos_in   = XW'(query_position_i);
  assign in_chain = pos_in < XW'(count_q);
  assign last_idx = XW'(count_q) - XW'(1);
  assign hi_sum   = pos_in + XW'(win_q);
  assign hi_in    = (hi_sum > last_idx) ? last_idx : hi_sum;
  assign lo_in    = (pos_in > XW'(win_q)) ? pos_in - XW'(win_q) : '0;
  assign clear_best = take_query && in_chain;

  // ---------------- chain length and memory ----------------
  assign wr_en   = take_append && (start_chain_i || (count_q < CW'(MAX_RESIDUES)));
  assign wr_addr = start_chain_i ? '0 : count_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (wr_en) begin
      count_q <= start_chain_i ? CW'(1) : count_q + CW'(1);
    end
  end

  assign rd_addr = (state_q == S_QRD) ? pos_q[AW-1:0] : p2_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {coord_z_i, coord_y_i, coord_x_i};
    end
    rd_data_q <= mem[rd_addr];
  end

  // ---------------- sweep sequencer ----------------
  assign sep    = (p2_q >= pos_q) ? p2_q - pos_q : pos_q - p2_q;
  assign finish = (state_q == S_DRAIN) && !pipe_active;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (clear_best) state_d = S_QRD;
      S_QRD:   state_d = S_QLD;
      S_QLD:   state_d = S_SWEEP;
      S_SWEEP: if (p2_q == hi_q) state_d = S_DRAIN;
      S_DRAIN: if (!pipe_active) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      s1_tap_q <= '0;
    end else begin
      state_q        <= state_d;
      s1_tap_q.valid <= (state_q == S_SWEEP);
      s1_tap_q.keep  <= sep > XW'(excl_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_best) begin
      pos_q <= pos_in;
      p2_q  <= lo_in;
      hi_q  <= hi_in;
    end else if (state_q == S_SWEEP) begin
      p2_q <= p2_q + XW'(1);
    end
    // Hold the queried residue once its read beat lands
    if (state_q == S_QLD) begin
      qcoord_q <= rd_data_q;
    end
  end

  wnrd_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clear_best),
    .qcoord_i  (qcoord_q),
    .rd_data_i (rd_data_q),
    .tap_i     (s1_tap_q),
    .best_o    (best),
    .found_o   (found),
    .active_o  (pipe_active)
  );

  // ---------------- result ----------------
  always_comb begin
    if (best < step_sq_q[0]) begin
      bin = 2'd0;
    end else if (best < step_sq_q[1]) begin
      bin = 2'd1;
    end else if (best < step_sq_q[2]) begin
      bin = 2'd2;
    end else begin
      bin = BIN_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= finish || (take_query && !in_chain);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_query && !in_chain) begin
      bin_q    <= BIN_NONE;
      dsq_q    <= DSQ_NONE;
      nf_q     <= 1'b0;
      status_q <= 1'b1;
    end else if (finish) begin
      bin_q    <= found ? bin : BIN_NONE;
      dsq_q    <= found ? DSQ_W'(best) : DSQ_NONE;
      nf_q     <= found;
      status_q <= 1'b0;
    end
  end

  assign done_o            = done_q;
  assign distance_bin_o    = bin_q;
  assign min_distance_sq_o = dsq_q;
  assign neighbor_found_o  = nf_q;
  assign status_o          = status_q;

endmodule

FILE: design/wnrd_checker.sv
// Port-level checks on the result channel of the distance bin block, with its bind.
// Depends on wnrd_pkg; attaches to windowed_nearest_residue_distance_bin_top.
`timescale 1ns / 1ps

module wnrd_checker import wnrd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             operation_i,
  input logic             done_o,
  input logic [1:0]       distance_bin_o,
  input logic [DSQ_W-1:0] min_distance_sq_o,
  input logic             neighbor_found_o,
  input logic             status_o
);

  // A result beat lands only once the sequencer is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result beat while busy");

  a_append_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (operation_i == OP_APPEND)) |=> !done_o)
    else $error("append produced a result beat");

  a_none_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !neighbor_found_o) |->
      (distance_bin_o == BIN_NONE) && (min_distance_sq_o == DSQ_NONE))
    else $error("empty search with wrong fields");

  a_status_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> !neighbor_found_o)
    else $error("out of chain query reports a neighbor");

  a_found_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && neighbor_found_o) |-> (min_distance_sq_o < DSQ_W'(CAP_SQ)))
    else $error("neighbor distance past the cap");

endmodule

bind windowed_nearest_residue_distance_bin_top wnrd_checker u_wnrd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .operation_i       (operation_i),
  .done_o            (done_o),
  .distance_bin_o    (distance_bin_o),
  .min_distance_sq_o (min_distance_sq_o),
  .neighbor_found_o  (neighbor_found_o),
  .status_o          (status_o)
);
